[rtl/tun_pkg.sv]
// ----------------------------------------------------------------------------
// tun_pkg
// Shared widths and beat types for the triangle unit normal pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int INDEX_WIDTH = 16;
   localparam int EDGE_SHIFT  = (COORD_WIDTH > 16) ? COORD_WIDTH - 16 : 0;
   localparam int EDGE_W      = 17;
   localparam int PROD_W      = 2 * EDGE_W;
   localparam int CROSS_W     = PROD_W + 1;
   localparam int MAG_W       = CROSS_W - 1;
   localparam int SQ_W        = 2 * MAG_W;
   localparam int SUM_W       = SQ_W + 2;
   localparam int ROOT_BITS   = 15;
   localparam int FRAC_SHIFT  = 30;
   localparam int WORK_W      = 108;
   localparam int UNIT_W      = 16;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0]     index;
      logic [2:0]                 neg;
      logic [2:0][MAG_W-1:0]      mag;
   } cross_beat_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0]     index;
      logic [2:0]                 neg;
      logic                       degenerate;
      logic [SUM_W-1:0]           sum;
      logic [2:0][WORK_W-1:0]     target;
   } norm_beat_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0]     index;
      logic [2:0]                 neg;
      logic                       degenerate;
      logic [2:0][ROOT_BITS-1:0]  root;
   } root_beat_type;

endpackage

[rtl/tun_cross.sv]
// ----------------------------------------------------------------------------
// tun_cross
// Edges, partial products and cross product, three register stages.
// ----------------------------------------------------------------------------
module tun_cross (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  adv,
   input  logic                                  in_valid,
   input  logic [tun_pkg::INDEX_WIDTH-1:0]       in_index,
   input  logic [2:0][2:0][tun_pkg::COORD_WIDTH-1:0] in_point,
   output logic                                  out_valid,
   output tun_pkg::cross_beat_type               out_beat
);
   import tun_pkg::*;

   logic [2:0]                      valid_ff;
   logic [INDEX_WIDTH-1:0]          index_ff [0:1];
   logic signed [EDGE_W-1:0]        e1_ff [0:2];
   logic signed [EDGE_W-1:0]        e2_ff [0:2];
   logic signed [EDGE_W-1:0]        e1_in [0:2];
   logic signed [EDGE_W-1:0]        e2_in [0:2];
   logic signed [PROD_W-1:0]        prod_ff [0:5];
   logic signed [CROSS_W-1:0]       cross_in [0:2];
   cross_beat_type                  beat_ff;
   cross_beat_type                  beat_in;

   // edges from the first vertex, floored down to the 17-bit datapath
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         e1_in[c] = EDGE_W'(($signed({in_point[1][c][COORD_WIDTH-1], in_point[1][c]})
                   - $signed({in_point[0][c][COORD_WIDTH-1], in_point[0][c]})) >>> EDGE_SHIFT);
         e2_in[c] = EDGE_W'(($signed({in_point[2][c][COORD_WIDTH-1], in_point[2][c]})
                   - $signed({in_point[0][c][COORD_WIDTH-1], in_point[0][c]})) >>> EDGE_SHIFT);
      end
   end

   always_comb begin
      cross_in[0] = $signed({prod_ff[0][PROD_W-1], prod_ff[0]})
                  - $signed({prod_ff[1][PROD_W-1], prod_ff[1]});
      cross_in[1] = $signed({prod_ff[2][PROD_W-1], prod_ff[2]})
                  - $signed({prod_ff[3][PROD_W-1], prod_ff[3]});
      cross_in[2] = $signed({prod_ff[4][PROD_W-1], prod_ff[4]})
                  - $signed({prod_ff[5][PROD_W-1], prod_ff[5]});
      beat_in.index = index_ff[1];
      for (int c = 0; c < 3; c++) begin
         beat_in.neg[c] = cross_in[c][CROSS_W-1];
         beat_in.mag[c] = cross_in[c][CROSS_W-1] ? MAG_W'(-cross_in[c])
                                                 : MAG_W'(cross_in[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         index_ff[0] <= in_index;
         index_ff[1] <= index_ff[0];
         for (int c = 0; c < 3; c++) begin
            e1_ff[c] <= e1_in[c];
            e2_ff[c] <= e2_in[c];
         end
         prod_ff[0] <= e1_ff[1] * e2_ff[2];
         prod_ff[1] <= e1_ff[2] * e2_ff[1];
         prod_ff[2] <= e1_ff[2] * e2_ff[0];
         prod_ff[3] <= e1_ff[0] * e2_ff[2];
         prod_ff[4] <= e1_ff[0] * e2_ff[1];
         prod_ff[5] <= e1_ff[1] * e2_ff[0];
         beat_ff    <= beat_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_beat  = beat_ff;

endmodule

[rtl/tun_norm.sv]
// ----------------------------------------------------------------------------
// tun_norm
// Squares of the cross product components and squared length, two stages.
// ----------------------------------------------------------------------------
module tun_norm (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  tun_pkg::cross_beat_type  in_beat,
   output logic                     out_valid,
   output tun_pkg::norm_beat_type   out_beat
);
   import tun_pkg::*;

   logic [1:0]              valid_ff;
   logic [SQ_W-1:0]         sq_ff [0:2];
   logic [INDEX_WIDTH-1:0]  index_ff;
   logic [2:0]              neg_ff;
   norm_beat_type           beat_ff;
   norm_beat_type           beat_in;

   always_comb begin
      beat_in.index      = index_ff;
      beat_in.neg        = neg_ff;
      beat_in.sum        = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
      beat_in.degenerate = (beat_in.sum == '0);
      for (int c = 0; c < 3; c++) begin
         beat_in.target[c] = WORK_W'(sq_ff[c]) << FRAC_SHIFT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            sq_ff[c] <= SQ_W'(in_beat.mag[c]) * SQ_W'(in_beat.mag[c]);
         end
         index_ff <= in_beat.index;
         neg_ff   <= in_beat.neg;
         beat_ff  <= beat_in;
      end
   end

   assign out_valid = valid_ff[1];
   assign out_beat  = beat_ff;

endmodule

[rtl/tun_search.sv]
// ----------------------------------------------------------------------------
// tun_search
// Exact rounded quotient 16384 |n| / sqrt(S), one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module tun_search (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  tun_pkg::norm_beat_type   in_beat,
   output logic                     out_valid,
   output tun_pkg::root_beat_type   out_beat
);
   import tun_pkg::*;

   // residual r = T - y^2 S, partial p = y S, with y = twice the root so far
   logic                    valid_ff [0:ROOT_BITS];
   logic [WORK_W-1:0]       r_ff     [0:ROOT_BITS-1][0:2];
   logic [WORK_W-1:0]       p_ff     [0:ROOT_BITS-1][0:2];
   logic [ROOT_BITS-1:0]    m_ff     [0:ROOT_BITS][0:2];
   logic [SUM_W-1:0]        s_ff     [0:ROOT_BITS-1];
   logic [INDEX_WIDTH-1:0]  index_ff [0:ROOT_BITS];
   logic [2:0]              neg_ff   [0:ROOT_BITS];
   logic                    degen_ff [0:ROOT_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s_ff[0]     <= in_beat.sum;
         index_ff[0] <= in_beat.index;
         neg_ff[0]   <= in_beat.neg;
         degen_ff[0] <= in_beat.degenerate;
         for (int c = 0; c < 3; c++) begin
            r_ff[0][c] <= in_beat.target[c];
            p_ff[0][c] <= '0;
            m_ff[0][c] <= '0;
         end
      end
   end

   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
      localparam int J = ROOT_BITS - 1 - k;

      logic [WORK_W-1:0] s_w;
      assign s_w = WORK_W'(s_ff[k]);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (adv) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            index_ff[k+1] <= index_ff[k];
            neg_ff[k+1]   <= neg_ff[k];
            degen_ff[k+1] <= degen_ff[k];
         end
      end

      // the last stage needs no squared length downstream
      if (k < ROOT_BITS - 1) begin : g_pass
         always_ff @(posedge clock) begin
            if (adv) begin
               s_ff[k+1] <= s_ff[k];
            end
         end
      end

      for (genvar c = 0; c < 3; c++) begin : g_comp
         logic [WORK_W-1:0] step_w;
         logic [WORK_W-1:0] lhs_w;
         logic [WORK_W-1:0] rhs_w;
         logic              take_w;

         // try root bit J: accept while (2m-1)^2 S stays within T
         assign step_w = (p_ff[k][c] << (J + 2)) + (s_w << (2 * J + 2));
         assign lhs_w  = step_w + s_w;
         assign rhs_w  = r_ff[k][c] + (p_ff[k][c] << 1) + (s_w << (J + 2));
         assign take_w = (lhs_w <= rhs_w);

         always_ff @(posedge clock) begin
            if (adv) begin
               m_ff[k+1][c] <= take_w ? (m_ff[k][c] | (ROOT_BITS'(1) << J))
                                      : m_ff[k][c];
            end
         end

         if (k < ROOT_BITS - 1) begin : g_carry
            always_ff @(posedge clock) begin
               if (adv) begin
                  if (take_w) begin
                     r_ff[k+1][c] <= r_ff[k][c] - step_w;
                     p_ff[k+1][c] <= p_ff[k][c] + (s_w << (J + 1));
                  end else begin
                     r_ff[k+1][c] <= r_ff[k][c];
                     p_ff[k+1][c] <= p_ff[k][c];
                  end
               end
            end
         end
      end
   end

   always_comb begin
      out_beat.index      = index_ff[ROOT_BITS];
      out_beat.neg        = neg_ff[ROOT_BITS];
      out_beat.degenerate = degen_ff[ROOT_BITS];
      for (int c = 0; c < 3; c++) begin
         out_beat.root[c] = m_ff[ROOT_BITS][c];
      end
   end

   assign out_valid = valid_ff[ROOT_BITS];

endmodule

[rtl/triangle_unit_normal_core.sv]
// Throughput: one triangle per cycle; every stage advances together and
// halts as a whole only while the response register holds an untaken beat.
// Depth is set by the 15-stage bit-per-stage root search.
// Reset: synchronous, active high; clears every stage valid bit, data is not reset.
// ----------------------------------------------------------------------------
// triangle_unit_normal_core
// Face normal of a Q8.8 triangle via cross product, scaled to unit length in
// Q1.14 with round-to-nearest; zero-length normals are flagged as degenerate.
// ----------------------------------------------------------------------------
module triangle_unit_normal_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [tun_pkg::INDEX_WIDTH-1:0]    req_vertex_index,
   input  logic [tun_pkg::COORD_WIDTH-1:0]    req_p1_x,
   input  logic [tun_pkg::COORD_WIDTH-1:0]    req_p1_y,
   input  logic [tun_pkg::COORD_WIDTH-1:0]    req_p1_z,
   input  logic [tun_pkg::COORD_WIDTH-1:0]    req_p2_x,
   input  logic [tun_pkg::COORD_WIDTH-1:0]    req_p2_y,
   input  logic [tun_pkg::COORD_WIDTH-1:0]    req_p2_z,
   input  logic [tun_pkg::COORD_WIDTH-1:0]    req_p3_x,
   input  logic [tun_pkg::COORD_WIDTH-1:0]    req_p3_y,
   input  logic [tun_pkg::COORD_WIDTH-1:0]    req_p3_z,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [tun_pkg::INDEX_WIDTH-1:0]    rsp_out_index,
   output logic signed [tun_pkg::UNIT_W-1:0]  rsp_normal_x,
   output logic signed [tun_pkg::UNIT_W-1:0]  rsp_normal_y,
   output logic signed [tun_pkg::UNIT_W-1:0]  rsp_normal_z,
   output logic                               rsp_degenerate
);
   import tun_pkg::*;

   logic                                  adv;
   logic [2:0][2:0][COORD_WIDTH-1:0]      point;
   logic                                  cross_valid;
   cross_beat_type                        cross_beat;
   logic                                  norm_valid;
   norm_beat_type                         norm_beat;
   logic                                  root_valid;
   root_beat_type                         root_beat;

   logic                                  rsp_valid_ff;
   logic [INDEX_WIDTH-1:0]                index_ff;
   logic [INDEX_WIDTH-1:0]                index_in;
   logic [2:0][UNIT_W-1:0]                normal_ff;
   logic [2:0][UNIT_W-1:0]                normal_in;
   logic                                  degen_ff;
   logic                                  degen_in;

   // Advance the whole pipeline unless the response register holds a beat
   // that the consumer has not taken; a bubble moves like a beat.
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   assign point[0] = {req_p1_z, req_p1_y, req_p1_x};
   assign point[1] = {req_p2_z, req_p2_y, req_p2_x};
   assign point[2] = {req_p3_z, req_p3_y, req_p3_x};

   // edges, products, cross product
   tun_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_index  (req_vertex_index),
      .in_point  (point),
      .out_valid (cross_valid),
      .out_beat  (cross_beat)
   );

   // squared components and squared length
   tun_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (cross_valid),
      .in_beat   (cross_beat),
      .out_valid (norm_valid),
      .out_beat  (norm_beat)
   );

   // bit-per-stage search for round(16384 |n| / sqrt(S))
   tun_search u_search (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (norm_valid),
      .in_beat   (norm_beat),
      .out_valid (root_valid),
      .out_beat  (root_beat)
   );

   // Apply the sign and drop the magnitude to zero on a degenerate face.
   always_comb begin
      index_in = root_beat.index;
      degen_in = root_beat.degenerate;
      for (int c = 0; c < 3; c++) begin
         if (root_beat.degenerate) begin
            normal_in[c] = '0;
         end else if (root_beat.neg[c]) begin
            normal_in[c] = -UNIT_W'(root_beat.root[c]);
         end else begin
            normal_in[c] = UNIT_W'(root_beat.root[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= root_valid;
      end
   end

   // hold the response payload while the consumer stalls
   always_ff @(posedge clock) begin
      if (adv) begin
         index_ff  <= index_in;
         normal_ff <= normal_in;
         degen_ff  <= degen_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_index  = index_ff;
   assign rsp_normal_x   = normal_ff[0];
   assign rsp_normal_y   = normal_ff[1];
   assign rsp_normal_z   = normal_ff[2];
   assign rsp_degenerate = degen_ff;

`ifndef SYNTH
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_normal_x <= 16'sd16384) && (rsp_normal_x >= -16'sd16384)
                 && (rsp_normal_y <= 16'sd16384) && (rsp_normal_y >= -16'sd16384)
                 && (rsp_normal_z <= 16'sd16384) && (rsp_normal_z >= -16'sd16384))
      else $error("normal component outside plus or minus one");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         (rsp_normal_x == '0) && (rsp_normal_y == '0) && (rsp_normal_z == '0))
      else $error("degenerate beat carries a nonzero normal");

   a_stall_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while the response stage is stalled");
`endif

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Triangle unit normal core testbench
// Streams triangles through the core under random idling and long output
// stalls, predicts each face normal independently and checks every beat.
// ----------------------------------------------------------------------------

typedef struct {
   logic [15:0]        index;
   logic signed [15:0] nx;
   logic signed [15:0] ny;
   logic signed [15:0] nz;
   logic               degenerate;
} normal_beat_type;

class normal_scoreboard;
   normal_beat_type pending[$];
   int              errors;

   // Round(16384 * n / sqrt(s)) by search on odd half-steps, exact integers.
   static function logic signed [15:0] unit_component(longint n, logic [127:0] s);
      logic [127:0] a;
      logic [127:0] t;
      logic [127:0] k;
      int lo;
      int hi;
      int mid;
      a = 128'((n < 0) ? -n : n);
      t = (a * a) << 30;
      lo = 0;
      hi = 16384;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         k = 128'(2 * mid - 1);
         if (k * k * s <= t) lo = mid;
         else hi = mid - 1;
      end
      return 16'((n < 0) ? -lo : lo);
   endfunction

   task report_mismatch(string msg);
      errors++;
      if (errors <= 50) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   function void note_triangle(logic [15:0] idx, logic signed [15:0] p [9]);
      normal_beat_type b;
      longint e1 [3];
      longint e2 [3];
      longint cx;
      longint cy;
      longint cz;
      logic [127:0] s;
      for (int c = 0; c < 3; c++) begin
         e1[c] = longint'(p[3 + c]) - longint'(p[c]);
         e2[c] = longint'(p[6 + c]) - longint'(p[c]);
      end
      cx = e1[1] * e2[2] - e1[2] * e2[1];
      cy = e1[2] * e2[0] - e1[0] * e2[2];
      cz = e1[0] * e2[1] - e1[1] * e2[0];
      // square in 128 bits: a component can reach 2^33
      s = 128'(cx) * 128'(cx) + 128'(cy) * 128'(cy) + 128'(cz) * 128'(cz);
      b.index = idx;
      b.degenerate = (s == 0);
      b.nx = b.degenerate ? 16'sd0 : unit_component(cx, s);
      b.ny = b.degenerate ? 16'sd0 : unit_component(cy, s);
      b.nz = b.degenerate ? 16'sd0 : unit_component(cz, s);
      pending = {pending, b};
   endfunction

   task check_normal(normal_beat_type got);
      normal_beat_type want;
      if (pending.size() == 0) begin
         report_mismatch("response beat with nothing pending");
         return;
      end
      want = pending.pop_front();
      if (got.index !== want.index)
         report_mismatch($sformatf("index got %0h want %0h", got.index, want.index));
      if (got.nx !== want.nx)
         report_mismatch($sformatf("normal_x got %0d want %0d (idx %0h)",
                                   got.nx, want.nx, want.index));
      if (got.ny !== want.ny)
         report_mismatch($sformatf("normal_y got %0d want %0d (idx %0h)",
                                   got.ny, want.ny, want.index));
      if (got.nz !== want.nz)
         report_mismatch($sformatf("normal_z got %0d want %0d (idx %0h)",
                                   got.nz, want.nz, want.index));
      if (got.degenerate !== want.degenerate)
         report_mismatch($sformatf("degenerate got %0b want %0b (idx %0h)",
                                   got.degenerate, want.degenerate, want.index));
   endtask
endclass

module tb;
   import tun_pkg::*;

   localparam int LATENCY = 22;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [15:0] req_vertex_index = '0;
   logic [15:0] req_p [9];
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [15:0] rsp_out_index;
   logic signed [15:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic rsp_degenerate;

   normal_scoreboard board = new();
   int  send_idle_pct = 7;
   int  recv_idle_pct = 73;
   int  hold_off      = 0;   // cycles the receiver must still stall

   initial for (int i = 0; i < 9; i++) req_p[i] = '0;

   triangle_unit_normal_core dut (
      .clock, .reset, .req_valid, .req_ready, .req_vertex_index,
      .req_p1_x(req_p[0]), .req_p1_y(req_p[1]), .req_p1_z(req_p[2]),
      .req_p2_x(req_p[3]), .req_p2_y(req_p[4]), .req_p2_z(req_p[5]),
      .req_p3_x(req_p[6]), .req_p3_y(req_p[7]), .req_p3_z(req_p[8]),
      .rsp_valid, .rsp_ready, .rsp_out_index, .rsp_normal_x, .rsp_normal_y,
      .rsp_normal_z, .rsp_degenerate);

   initial begin
      forever #6 clock = ~clock;
   end

   // Receiver: stall at random, or hold off entirely while a long stall runs.
   always @(posedge clock) begin
      normal_beat_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.index = rsp_out_index;
         got.nx = rsp_normal_x;
         got.ny = rsp_normal_y;
         got.nz = rsp_normal_z;
         got.degenerate = rsp_degenerate;
         board.check_normal(got);
      end
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Present one triangle beat, idling first at the current rate; hold until taken.
   task automatic send_triangle(logic [15:0] idx, logic [15:0] p [9]);
      logic signed [15:0] sp [9];
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_vertex_index <= idx;
      for (int i = 0; i < 9; i++) req_p[i] <= p[i];
      do @(posedge clock); while (!req_ready);
      for (int i = 0; i < 9; i++) sp[i] = p[i];
      board.note_triangle(idx, sp);
   endtask

   // Draw a coordinate: mostly small, sometimes full range or an extreme.
   function automatic logic [15:0] pick_coord();
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2, 3, 4: return 16'($urandom());
         default: return 16'($urandom_range(1023) - 512);
      endcase
   endfunction

   task automatic send_random(int count);
      logic [15:0] p [9];
      for (int n = 0; n < count; n++) begin
         for (int i = 0; i < 9; i++) p[i] = pick_coord();
         // Occasionally collapse the triangle: repeated or collinear vertices.
         case ($urandom_range(19))
            0: for (int c = 0; c < 3; c++) p[3 + c] = p[c];
            1: for (int c = 0; c < 3; c++) p[6 + c] = p[3 + c];
            2: for (int c = 0; c < 3; c++) p[6 + c] = 16'(2 * p[3 + c] - p[c]);
            default: ;
         endcase
         send_triangle(16'($urandom()), p);
      end
   endtask

   // Drop the request and wait for every outstanding normal.
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [15:0] p [9];
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: axis-aligned faces, extremes, degenerate and wide edges.
      p = '{16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000,
            16'h0000, 16'h0100, 16'h0000};
      send_triangle(16'h0000, p);
      p = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000,
            16'h0000, 16'h0000, 16'h0100};
      send_triangle(16'hffff, p);
      p = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0100,
            16'h0100, 16'h0000, 16'h0000};
      send_triangle(16'h8000, p);
      p = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000,
            16'h0100, 16'h0000, 16'h0000};
      send_triangle(16'h0001, p);
      for (int i = 0; i < 9; i++) p[i] = 16'h1234;
      send_triangle(16'h7fff, p);
      p = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
            16'h8000, 16'h7fff, 16'h8000};
      send_triangle(16'h5555, p);
      p = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
            16'h8000, 16'h8000, 16'h7fff};
      send_triangle(16'haaaa, p);
      p = '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
            16'h7fff, 16'h7fff, 16'h8000};
      send_triangle(16'h0f0f, p);
      p = '{16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'h0000,
            16'h0001, 16'h0000, 16'h0001};
      send_triangle(16'hf0f0, p);
      // Tie-prone small edges and collinear points.
      p = '{16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0002, 16'h0003,
            16'h0002, 16'h0004, 16'h0006};
      send_triangle(16'h1111, p);
      p = '{16'h0000, 16'h0000, 16'h0000, 16'h0003, 16'h0000, 16'h0000,
            16'h0000, 16'h0004, 16'h0000};
      send_triangle(16'h2222, p);
      p = '{16'hffff, 16'hffff, 16'hffff, 16'h0001, 16'h0002, 16'h0000,
            16'hfffe, 16'h0001, 16'h0003};
      send_triangle(16'h3333, p);

      // Receiver mostly stalls; then hold it off while the sender fills the pipe.
      send_random(300);
      hold_off = 120;
      send_random(60);
      drain();
      // Now the sender mostly idles while the receiver is mostly ready.
      send_idle_pct = 73;
      recv_idle_pct = 7;
      send_random(300);
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(280);
      drain();
      repeat (LATENCY + 8) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("triangle_unit_normal_core: match");
      else
         $display("triangle_unit_normal_core: mismatch");
      $finish;
   end

   initial begin
      #5ms;
      $display("triangle_unit_normal_core: mismatch");
      $finish;
   end
endmodule

[triangle_unit_normal_core.f]
rtl/tun_pkg.sv
rtl/tun_cross.sv
rtl/tun_norm.sv
rtl/tun_search.sv
rtl/triangle_unit_normal_core.sv
sim/tb.sv
